// ----- src/tekd_pkg.sv -----
// Shared types and constants for the terminal escape key decoder.
// Used by the parser, the output register and the top level.
// No dependencies.
`default_nettype none

package tekd_pkg;

  // Byte codes the parser looks for
  localparam logic [7:0] ESC_BYTE   = 8'd27;
  localparam logic [7:0] NULL_BYTE  = 8'd0;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;  // '['
  localparam logic [7:0] CH_SS3     = 8'h4F;  // 'O'
  localparam logic [7:0] CH_TILDE   = 8'h7E;  // '~'
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_DIGIT_1 = 8'h31;
  localparam logic [7:0] CH_DIGIT_2 = 8'h32;
  localparam logic [7:0] CH_DIGIT_3 = 8'h33;
  localparam logic [7:0] CH_DIGIT_4 = 8'h34;
  localparam logic [7:0] CH_DIGIT_5 = 8'h35;
  localparam logic [7:0] CH_DIGIT_6 = 8'h36;
  localparam logic [7:0] CH_DIGIT_7 = 8'h37;
  localparam logic [7:0] CH_DIGIT_8 = 8'h38;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;  // '9'
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_Q       = 8'h51;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_S       = 8'h53;

  // Result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Key codes
  localparam logic [4:0] KEY_UP    = 5'd0;
  localparam logic [4:0] KEY_DOWN  = 5'd1;
  localparam logic [4:0] KEY_RIGHT = 5'd2;
  localparam logic [4:0] KEY_LEFT  = 5'd3;
  localparam logic [4:0] KEY_HOME  = 5'd4;
  localparam logic [4:0] KEY_END   = 5'd5;
  localparam logic [4:0] KEY_INS   = 5'd6;
  localparam logic [4:0] KEY_DEL   = 5'd7;
  localparam logic [4:0] KEY_PGUP  = 5'd8;
  localparam logic [4:0] KEY_PGDN  = 5'd9;
  localparam logic [4:0] KEY_ESC   = 5'd10;
  localparam logic [4:0] KEY_F1    = 5'd11;
  localparam logic [4:0] KEY_F2    = 5'd12;
  localparam logic [4:0] KEY_F3    = 5'd13;
  localparam logic [4:0] KEY_F4    = 5'd14;
  localparam logic [4:0] KEY_F5    = 5'd15;
  localparam logic [4:0] KEY_F6    = 5'd16;
  localparam logic [4:0] KEY_F7    = 5'd17;
  localparam logic [4:0] KEY_F8    = 5'd18;
  localparam logic [4:0] KEY_F9    = 5'd19;
  localparam logic [4:0] KEY_F10   = 5'd20;
  localparam logic [4:0] KEY_F11   = 5'd21;
  localparam logic [4:0] KEY_F12   = 5'd22;

  // Error codes
  localparam logic [2:0] ERR_TILDE_DIGIT = 3'd0;
  localparam logic [2:0] ERR_TWO_DIGIT   = 3'd1;
  localparam logic [2:0] ERR_NO_TILDE    = 3'd2;
  localparam logic [2:0] ERR_CSI_LETTER  = 3'd3;
  localparam logic [2:0] ERR_SS3_LETTER  = 3'd4;
  localparam logic [2:0] ERR_PREFIX      = 3'd5;

  // Parse phase
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_AFTER_ESC  = 3'd1,
    PH_AFTER_PFX  = 3'd2,
    PH_CSI_DIGIT  = 3'd3,
    PH_CSI_TWO    = 3'd4
  } phase_t;

  // One decoded result word
  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] char_value;
    logic [4:0] key_code;
    logic [2:0] error_code;
    logic [7:0] error_byte;
  } result_t;

endpackage

`default_nettype wire

// ----- src/tekd_byte_if.sv -----
// Input channel carrying one received terminal byte per word.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface tekd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- src/tekd_result_if.sv -----
// Output channel carrying one decoded result word.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface tekd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] char_value;
  logic [4:0] key_code;
  logic [2:0] error_code;
  logic [7:0] error_byte;

  modport source (output valid, output result_kind, output char_value, output key_code,
                  output error_code, output error_byte, input ready);
  modport sink   (input valid, input result_kind, input char_value, input key_code,
                  input error_code, input error_byte, output ready);
endinterface

`default_nettype wire

// ----- src/terminal_escape_key_decoder.sv -----
// Top level of the terminal escape key decoder: input register, parser, result register.
// Depends on tekd_pkg, tekd_byte_if, tekd_result_if, tekd_parser and tekd_out_reg.
`default_nettype none

// Decodes a stream of terminal bytes into plain characters, special keys and
// errors for unrecognized escape sequences. Byte 0 stands for a read timeout.
// One byte is accepted every cycle unless the block stalls; each result
// passes through the input register, then the result register. Bytes inside
// an escape sequence that do not finish it give no word. The block only stalls
// when a result is waiting in the result register and the sink is not ready.
module terminal_escape_key_decoder (
  input  wire logic      clk,
  input  wire logic      rst,
  tekd_byte_if.sink      rx,
  tekd_result_if.source  keys
);

  logic              inq_valid;
  logic [7:0]        inq_byte;
  logic              has_result;
  logic              can_take;
  logic              consume;
  tekd_pkg::result_t result;

  // a held byte moves on unless its result has nowhere to go
  assign consume  = inq_valid && (!has_result || can_take);
  assign rx.ready = !inq_valid || consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (rx.ready) begin
      inq_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      inq_byte <= rx.in_byte;
    end
  end

  tekd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (inq_byte),
    .advance    (consume),
    .has_result (has_result),
    .result     (result)
  );

  tekd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (consume && has_result),
    .result   (result),
    .can_take (can_take),
    .keys     (keys)
  );

endmodule

`default_nettype wire

// ----- src/tekd_parser.sv -----
// Escape sequence phase machine and byte decoder.
// Holds the parse phase and the gathered sequence bytes; depends on tekd_pkg.
`default_nettype none

module tekd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        in_byte,
  input  wire logic              advance,     // byte is consumed this cycle
  output      logic              has_result,
  output      tekd_pkg::result_t result
);

  tekd_pkg::phase_t phase, phase_next;
  logic [7:0] prefix_byte, prefix_byte_next;
  logic [7:0] second_byte, second_byte_next;
  logic [7:0] third_byte,  third_byte_next;
  logic       is_digit;

  assign is_digit = (in_byte >= tekd_pkg::CH_DIGIT_0) && (in_byte <= tekd_pkg::CH_DIGIT_9);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tekd_pkg::PH_IDLE;
      prefix_byte <= '0;
      second_byte <= '0;
      third_byte  <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      prefix_byte <= prefix_byte_next;
      second_byte <= second_byte_next;
      third_byte  <= third_byte_next;
    end
  end

  // Next phase and result
  always_comb begin
    phase_next       = phase;
    prefix_byte_next = prefix_byte;
    second_byte_next = second_byte;
    third_byte_next  = third_byte;
    has_result       = 1'b0;
    result           = '0;

    unique case (phase)
      tekd_pkg::PH_AFTER_ESC: begin
        prefix_byte_next = in_byte;
        phase_next       = tekd_pkg::PH_AFTER_PFX;
      end

      tekd_pkg::PH_AFTER_PFX: begin
        second_byte_next = in_byte;
        if (prefix_byte == tekd_pkg::CH_LBRACK) begin
          if (is_digit) begin
            phase_next = tekd_pkg::PH_CSI_DIGIT;
          end else begin
            has_result         = 1'b1;
            result.result_kind = tekd_pkg::KIND_KEY;
            case (in_byte)
              tekd_pkg::CH_A: result.key_code = tekd_pkg::KEY_UP;
              tekd_pkg::CH_B: result.key_code = tekd_pkg::KEY_DOWN;
              tekd_pkg::CH_C: result.key_code = tekd_pkg::KEY_RIGHT;
              tekd_pkg::CH_D: result.key_code = tekd_pkg::KEY_LEFT;
              tekd_pkg::CH_H: result.key_code = tekd_pkg::KEY_HOME;
              tekd_pkg::CH_F: result.key_code = tekd_pkg::KEY_END;
              default: begin
                result.result_kind = tekd_pkg::KIND_ERR;
                result.error_code  = tekd_pkg::ERR_CSI_LETTER;
                result.error_byte  = in_byte;
              end
            endcase
          end
        end else if (prefix_byte == tekd_pkg::CH_SS3) begin
          has_result         = 1'b1;
          result.result_kind = tekd_pkg::KIND_KEY;
          case (in_byte)
            tekd_pkg::CH_H: result.key_code = tekd_pkg::KEY_HOME;
            tekd_pkg::CH_F: result.key_code = tekd_pkg::KEY_END;
            tekd_pkg::CH_P: result.key_code = tekd_pkg::KEY_F1;
            tekd_pkg::CH_Q: result.key_code = tekd_pkg::KEY_F2;
            tekd_pkg::CH_R: result.key_code = tekd_pkg::KEY_F3;
            tekd_pkg::CH_S: result.key_code = tekd_pkg::KEY_F4;
            default: begin
              result.result_kind = tekd_pkg::KIND_ERR;
              result.error_code  = tekd_pkg::ERR_SS3_LETTER;
              result.error_byte  = in_byte;
            end
          endcase
        end else if (prefix_byte == tekd_pkg::NULL_BYTE) begin
          // ESC then timeout: escape key
          has_result         = 1'b1;
          result.result_kind = tekd_pkg::KIND_KEY;
          result.key_code    = tekd_pkg::KEY_ESC;
        end else begin
          has_result         = 1'b1;
          result.result_kind = tekd_pkg::KIND_ERR;
          result.error_code  = tekd_pkg::ERR_PREFIX;
          result.error_byte  = prefix_byte;
        end
      end

      tekd_pkg::PH_CSI_DIGIT: begin
        if (in_byte == tekd_pkg::CH_TILDE) begin
          has_result         = 1'b1;
          result.result_kind = tekd_pkg::KIND_KEY;
          case (second_byte) inside
            tekd_pkg::CH_DIGIT_1, tekd_pkg::CH_DIGIT_7: result.key_code = tekd_pkg::KEY_HOME;
            tekd_pkg::CH_DIGIT_4, tekd_pkg::CH_DIGIT_8: result.key_code = tekd_pkg::KEY_END;
            tekd_pkg::CH_DIGIT_2: result.key_code = tekd_pkg::KEY_INS;
            tekd_pkg::CH_DIGIT_3: result.key_code = tekd_pkg::KEY_DEL;
            tekd_pkg::CH_DIGIT_5: result.key_code = tekd_pkg::KEY_PGUP;
            tekd_pkg::CH_DIGIT_6: result.key_code = tekd_pkg::KEY_PGDN;
            default: begin
              result.result_kind = tekd_pkg::KIND_ERR;
              result.error_code  = tekd_pkg::ERR_TILDE_DIGIT;
              result.error_byte  = second_byte;
            end
          endcase
        end else begin
          third_byte_next = in_byte;
          phase_next      = tekd_pkg::PH_CSI_TWO;
        end
      end

      tekd_pkg::PH_CSI_TWO: begin
        has_result = 1'b1;
        if (in_byte != tekd_pkg::CH_TILDE) begin
          result.result_kind = tekd_pkg::KIND_ERR;
          result.error_code  = tekd_pkg::ERR_NO_TILDE;
          result.error_byte  = in_byte;
        end else begin
          // only the second digit selects the function key
          result.result_kind = tekd_pkg::KIND_KEY;
          case (third_byte)
            tekd_pkg::CH_DIGIT_5: result.key_code = tekd_pkg::KEY_F5;
            tekd_pkg::CH_DIGIT_7: result.key_code = tekd_pkg::KEY_F6;
            tekd_pkg::CH_DIGIT_8: result.key_code = tekd_pkg::KEY_F7;
            tekd_pkg::CH_DIGIT_9: result.key_code = tekd_pkg::KEY_F8;
            tekd_pkg::CH_DIGIT_0: result.key_code = tekd_pkg::KEY_F9;
            tekd_pkg::CH_DIGIT_1: result.key_code = tekd_pkg::KEY_F10;
            tekd_pkg::CH_DIGIT_3: result.key_code = tekd_pkg::KEY_F11;
            tekd_pkg::CH_DIGIT_4: result.key_code = tekd_pkg::KEY_F12;
            default: begin
              result.result_kind = tekd_pkg::KIND_ERR;
              result.error_code  = tekd_pkg::ERR_TWO_DIGIT;
              result.error_byte  = third_byte;
            end
          endcase
        end
      end

      default: begin
        // idle, and unused phase codes
        if (in_byte == tekd_pkg::ESC_BYTE) begin
          phase_next       = tekd_pkg::PH_AFTER_ESC;
          prefix_byte_next = '0;
          second_byte_next = '0;
          third_byte_next  = '0;
        end else begin
          has_result         = 1'b1;
          result.result_kind = tekd_pkg::KIND_CHAR;
          result.char_value  = in_byte;
        end
      end
    endcase

    // every result ends the sequence
    if (has_result) begin
      phase_next       = tekd_pkg::PH_IDLE;
      prefix_byte_next = '0;
      second_byte_next = '0;
      third_byte_next  = '0;
    end
  end

endmodule

`default_nettype wire

// ----- src/tekd_out_reg.sv -----
// Result register driving the output channel.
// Takes a new word whenever it is empty or its word is taken; depends on tekd_pkg.
`default_nettype none

module tekd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire tekd_pkg::result_t result,
  output      logic              can_take,
  tekd_result_if.source          keys
);

  logic              valid;
  tekd_pkg::result_t data;

  assign can_take = !valid || keys.ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (keys.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign keys.valid       = valid;
  assign keys.result_kind = data.result_kind;
  assign keys.char_value  = data.char_value;
  assign keys.key_code    = data.key_code;
  assign keys.error_code  = data.error_code;
  assign keys.error_byte  = data.error_byte;

endmodule

`default_nettype wire
